@@ rtl/status_led_sequencer_core_macros.svh @@
// Assertion macros used by the status LED sequencer checker.
`ifndef STATUS_LED_SEQUENCER_CORE_MACROS_SVH
`define STATUS_LED_SEQUENCER_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SLS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define SLS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define SLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/sls_pkg.sv @@
// Types and constants of the status LED sequencer.
`default_nettype none

package sls_pkg;

  localparam int unsigned LIMIT_W = 10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd60;

  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] START_LAST_STEP = 4'd14;

  // LED bit positions in the level vector
  localparam int unsigned LED_RUN  = 0;
  localparam int unsigned LED_BUS  = 1;
  localparam int unsigned LED_CELL = 2;
  localparam int unsigned LED_SAT  = 3;

  // Enable bit positions, also the led_select codes
  localparam logic [1:0] SEL_BUS  = 2'd0;
  localparam logic [1:0] SEL_CELL = 2'd1;
  localparam logic [1:0] SEL_SAT  = 2'd2;

  // Register word index on the APB port
  localparam logic REG_FAULT_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SLEEP  = 2'd1,
    OP_WAKE   = 2'd2,
    OP_SET_EN = 2'd3
  } op_e;

  typedef struct packed {
    op_e        operation;
    logic       bus_busy;
    logic       cell_connected;
    logic       antenna_short;
    logic       position_fixed;
    logic [1:0] led_select;
    logic       enable_value;
  } sls_item_t;

  typedef struct packed {
    logic run_led;
    logic bus_led;
    logic cell_led;
    logic sat_led;
    logic slow_period;
  } sls_result_t;

endpackage

`default_nettype wire

@@ rtl/sls_cfg.sv @@
// APB register block holding the antenna fault limit.
`default_nettype none

module sls_cfg import sls_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic [LIMIT_W-1:0]      limit_o
);

  logic [LIMIT_W-1:0] limit_q;
  logic               wr_en;
  logic               hit;

  assign hit   = (paddr[2] == REG_FAULT_LIMIT);
  assign wr_en = psel & penable & pwrite & hit;

  // Limit register, written in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (wr_en) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(32-LIMIT_W){1'b0}}, limit_q};
    end
  end

  assign limit_o = limit_q;

endmodule

`default_nettype wire

@@ rtl/sls_engine.sv @@
// Sequencer state and next-state logic: lamp test, run mode, sleep/wake, LED enables.
`default_nettype none

module sls_engine import sls_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_en_i,
  input  wire sls_item_t          item_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output sls_result_t             result_o
);

  logic              run_mode_q, run_mode_d;
  logic              asleep_q, asleep_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [LIMIT_W-1:0] cnt_q, cnt_d;
  logic [3:0]        lvl_q, lvl_d;
  logic [2:0]        en_q, en_d;

  logic [LIMIT_W-1:0] cnt_inc;
  logic               held;
  logic               sat_off;

  // Antenna fault counter saturates at the limit
  assign cnt_inc = (cnt_q < limit_i) ? cnt_q + 1'b1 : cnt_q;
  assign held    = item_i.antenna_short && (cnt_inc >= limit_i);
  assign sat_off = !en_q[SEL_SAT] || (!held && !item_i.position_fixed);

  // Next state for one item
  always_comb begin
    run_mode_d = run_mode_q;
    asleep_d   = asleep_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    lvl_d      = lvl_q;
    en_d       = en_q;
    unique case (item_i.operation)
      OP_TICK: begin
        if (!asleep_q && run_mode_q) begin
          cnt_d = item_i.antenna_short ? cnt_inc : '0;
          lvl_d[LED_RUN] = !lvl_q[LED_RUN];
          lvl_d[LED_BUS] = (en_q[SEL_BUS] && item_i.bus_busy) ? !lvl_q[LED_BUS] : 1'b0;
          lvl_d[LED_CELL] = (en_q[SEL_CELL] && item_i.cell_connected) ?
                            !lvl_q[LED_CELL] : 1'b0;
          if (sat_off) begin
            lvl_d[LED_SAT] = 1'b0;
          end else if (held) begin
            lvl_d[LED_SAT] = 1'b1;
          end else begin
            lvl_d[LED_SAT] = !lvl_q[LED_SAT];
          end
        end else if (!asleep_q) begin
          // Lamp test: one step per tick
          step_d = step_q + 1'b1;
          unique case (step_q)
            4'd0, 4'd9:   lvl_d = '0;
            4'd5, 4'd10:  lvl_d[LED_RUN] = 1'b1;
            4'd6, 4'd11:  lvl_d[LED_BUS] = 1'b1;
            4'd7, 4'd12:  lvl_d[LED_SAT] = 1'b1;
            4'd8, 4'd13:  lvl_d[LED_CELL] = 1'b1;
            START_LAST_STEP: begin
              lvl_d      = '0;
              step_d     = '0;
              run_mode_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_SLEEP: begin
        asleep_d = 1'b1;
        lvl_d    = '0;
      end
      OP_WAKE: begin
        run_mode_d = 1'b0;
        asleep_d   = 1'b0;
        step_d     = '0;
        cnt_d      = '0;
        en_d       = '1;
      end
      OP_SET_EN: begin
        if (item_i.led_select <= SEL_SAT) begin
          en_d[item_i.led_select] = item_i.enable_value;
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q <= 1'b0;
      asleep_q   <= 1'b0;
      step_q     <= '0;
      cnt_q      <= '0;
      lvl_q      <= '0;
      en_q       <= '1;
    end else if (step_en_i) begin
      run_mode_q <= run_mode_d;
      asleep_q   <= asleep_d;
      step_q     <= step_d;
      cnt_q      <= cnt_d;
      lvl_q      <= lvl_d;
      en_q       <= en_d;
    end
  end

  // Result of this item
  assign result_o.run_led     = lvl_d[LED_RUN];
  assign result_o.bus_led     = lvl_d[LED_BUS];
  assign result_o.cell_led    = lvl_d[LED_CELL];
  assign result_o.sat_led     = lvl_d[LED_SAT];
  assign result_o.slow_period = run_mode_d && !asleep_d;

endmodule

`default_nettype wire

@@ rtl/status_led_sequencer_core.sv @@
// Top level of the status LED sequencer: item register, engine, APB config, result register.
`default_nettype none

// Status LED sequencer for run, bus, cellular and satellite LEDs. Each input
// item (tick, sleep, wake or set-enable) yields exactly one result item with
// the four LED levels and the tick period request. An item is captured in an
// input register, the sequencer state is updated by combinational next-state
// logic, and the result is held in an output register: tvalid on the result
// side rises when the item moves on from the input register into the result
// register, which waits while a held result has not been taken. A new item is
// taken every cycle while the result side keeps up (one item per cycle). The
// antenna fault limit is set through the APB port at byte address 0 and
// should only be written while idle.
module status_led_sequencer_core import sls_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] bus_busy, [1] cell_connected, [2] antenna_short, [3] position_fixed,
  // [5:4] led_select, [6] enable_value, [7] zero
  input  wire logic [7:0]  s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  // Result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] run_led, [1] bus_led, [2] cell_led, [3] sat_led, [4] slow_period,
  // [7:5] zero
  output logic [7:0]       m_axis_tdata,
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic               in_vld_q;
  sls_item_t          item_q, item_in;
  logic               out_vld_q;
  sls_result_t        res_q, res_d;
  logic               adv;
  logic [LIMIT_W-1:0] limit;

  assign pready = 1'b1;

  // Unpack the incoming item
  assign item_in.operation      = op_e'(s_axis_tuser);
  assign item_in.bus_busy       = s_axis_tdata[0];
  assign item_in.cell_connected = s_axis_tdata[1];
  assign item_in.antenna_short  = s_axis_tdata[2];
  assign item_in.position_fixed = s_axis_tdata[3];
  assign item_in.led_select     = s_axis_tdata[5:4];
  assign item_in.enable_value   = s_axis_tdata[6];

  // Pipeline moves when the result register is free or being drained
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q <= item_in;
    end
  end

  sls_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .limit_o (limit)
  );

  sls_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (in_vld_q && adv),
    .item_i    (item_q),
    .limit_i   (limit),
    .result_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && adv) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, res_q.slow_period, res_q.sat_led, res_q.cell_led,
                          res_q.bus_led, res_q.run_led};

endmodule

`default_nettype wire

@@ rtl/sls_checker.sv @@
// Port-level checks of the status LED sequencer and their bind.
`default_nettype none

`include "status_led_sequencer_core_macros.svh"

module sls_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       pready
);

  // APB never inserts wait states
  `SLS_ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready)

  // An empty result register always leaves room for a new item
  `SLS_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // Input side only stalls because of a held result
  `SLS_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !s_axis_tready,
                   m_axis_tvalid && !m_axis_tready)

  // A stalled result holds
  `SLS_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind status_led_sequencer_core sls_checker u_sls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);

`default_nettype wire

@@ tb/sv/status_led_sequencer_core_tb.sv @@
// Self-checking testbench for the status LED sequencer core.
`timescale 1ns / 1ps

module status_led_sequencer_core_tb;
  import sls_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SLOW_BIT = 4;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned LONG_HOLD = 80;

  // Indication applied to one LED on a run tick
  typedef enum logic [1:0] {
    IND_NORMAL   = 2'd0,
    IND_ERROR    = 2'd1,
    IND_ABNORMAL = 2'd2
  } led_ind_e;

  // One row of the directed table
  typedef struct packed {
    sls_item_t   item;
    logic        has_fixed;
    sls_result_t fixed;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  status_led_sequencer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted sequencer state
  logic               in_run;
  logic               sleeping;
  logic [STEP_W-1:0]  lamp_step;
  logic [LIMIT_W-1:0] fault_cnt;
  logic [LIMIT_W-1:0] fault_limit;
  logic [3:0]         leds;      // indexed by LED_RUN .. LED_SAT
  logic [2:0]         led_en;    // indexed by SEL_BUS .. SEL_SAT
  led_ind_e           sat_ind;

  sls_result_t expected_leds_q[$];
  stim_row_t   stim_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned rx_gap = 0;
  logic        idle_en = 1'b1;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic void restart_sequence();
    in_run    = 1'b0;
    sleeping  = 1'b0;
    lamp_step = '0;
    fault_cnt = '0;
    led_en    = 3'b111;
    sat_ind   = IND_NORMAL;
  endfunction

  function automatic logic next_level(logic cur, logic en, led_ind_e ind);
    if (!en || ind == IND_ABNORMAL) return 1'b0;
    if (ind == IND_ERROR) return 1'b1;
    return ~cur;
  endfunction

  // Advance the predicted state by one item and return the LED levels after it
  function automatic sls_result_t predict_leds(sls_item_t it);
    sls_result_t       r;
    logic              held;
    logic [STEP_W-1:0] s;
    held = 1'b0;
    s = lamp_step;
    case (it.operation)
      OP_TICK: begin
        if (!sleeping && in_run) begin
          // antenna short must persist for the limit before the LED is held on
          if (it.antenna_short) begin
            if (fault_cnt < fault_limit) fault_cnt = fault_cnt + 1'b1;
            if (fault_cnt >= fault_limit) begin
              sat_ind = IND_ERROR;
              held = 1'b1;
            end
          end else begin
            fault_cnt = '0;
          end
          if (!held) sat_ind = it.position_fixed ? IND_NORMAL : IND_ABNORMAL;
          leds[LED_RUN] = ~leds[LED_RUN];
          leds[LED_BUS] = next_level(leds[LED_BUS], led_en[SEL_BUS],
                                     it.bus_busy ? IND_NORMAL : IND_ABNORMAL);
          leds[LED_SAT] = next_level(leds[LED_SAT], led_en[SEL_SAT], sat_ind);
          leds[LED_CELL] = next_level(leds[LED_CELL], led_en[SEL_CELL],
                                      it.cell_connected ? IND_NORMAL : IND_ABNORMAL);
        end else if (!sleeping) begin
          // lamp test: two passes of run, bus, sat, cell lighting up
          lamp_step = lamp_step + 1'b1;
          case (s)
            4'd0, 4'd9:  leds = '0;
            4'd5, 4'd10: leds[LED_RUN] = 1'b1;
            4'd6, 4'd11: leds[LED_BUS] = 1'b1;
            4'd7, 4'd12: leds[LED_SAT] = 1'b1;
            4'd8, 4'd13: leds[LED_CELL] = 1'b1;
            START_LAST_STEP: begin
              leds = '0;
              lamp_step = '0;
              in_run = 1'b1;
            end
            default: ;
          endcase
        end
      end
      OP_SLEEP: begin
        sleeping = 1'b1;
        leds = '0;
      end
      OP_WAKE: restart_sequence();
      OP_SET_EN: begin
        if (it.led_select <= SEL_SAT) led_en[it.led_select] = it.enable_value;
      end
      default: ;
    endcase
    r.run_led     = leds[LED_RUN];
    r.bus_led     = leds[LED_BUS];
    r.cell_led    = leds[LED_CELL];
    r.sat_led     = leds[LED_SAT];
    r.slow_period = in_run && !sleeping;
    return r;
  endfunction

  // fixed result bits in order run, bus, cell, sat, slow
  function automatic void add_row(op_e op, logic bus, logic cell_con, logic ant, logic pos,
                                  logic [1:0] sel, logic en, logic has_fixed,
                                  sls_result_t fixed);
    stim_row_t row;
    row.item.operation      = op;
    row.item.bus_busy       = bus;
    row.item.cell_connected = cell_con;
    row.item.antenna_short  = ant;
    row.item.position_fixed = pos;
    row.item.led_select     = sel;
    row.item.enable_value   = en;
    row.has_fixed           = has_fixed;
    row.fixed               = fixed;
    stim_rows.push_back(row);
  endfunction

  // Offer one item, wait for acceptance, queue its expected LED levels
  task automatic send_event(input sls_item_t it, input logic has_fixed,
                            input sls_result_t fixed);
    sls_result_t want;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.operation;
    s_axis_tdata  <= {1'b0, it.enable_value, it.led_select, it.position_fixed,
                      it.antenna_short, it.cell_connected, it.bus_busy};
    do @(posedge clk_i); while (!s_axis_tready);
    want = predict_leds(it);
    if (has_fixed) want = fixed;
    expected_leds_q.push_back(want);
    items_sent++;
  endtask

  // Stop offering, then wait for all results plus the pipeline depth
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_leds_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // APB write: setup phase then access phase, then the bus returns to idle
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_FAULT_LIMIT) fault_limit = data[LIMIT_W-1:0];
    @(posedge clk_i);
  endtask

  // APB read of the fault limit, checked against the predicted value
  task automatic check_limit_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_FAULT_LIMIT, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(32-LIMIT_W){1'b0}}, fault_limit})
      report_mismatch($sformatf("fault limit read %0h, want %0h", prdata, fault_limit));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result checking and receiver back-pressure
  always @(posedge clk_i) begin
    sls_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_leds_q.size() == 0) begin
        report_mismatch($sformatf("result %02h with nothing expected", m_axis_tdata));
      end else begin
        want = expected_leds_q.pop_front();
        if (m_axis_tdata[LED_RUN] !== want.run_led)
          report_mismatch($sformatf("result %0d run_led %b, want %b", results_seen,
                                    m_axis_tdata[LED_RUN], want.run_led));
        if (m_axis_tdata[LED_BUS] !== want.bus_led)
          report_mismatch($sformatf("result %0d bus_led %b, want %b", results_seen,
                                    m_axis_tdata[LED_BUS], want.bus_led));
        if (m_axis_tdata[LED_CELL] !== want.cell_led)
          report_mismatch($sformatf("result %0d cell_led %b, want %b", results_seen,
                                    m_axis_tdata[LED_CELL], want.cell_led));
        if (m_axis_tdata[LED_SAT] !== want.sat_led)
          report_mismatch($sformatf("result %0d sat_led %b, want %b", results_seen,
                                    m_axis_tdata[LED_SAT], want.sat_led));
        if (m_axis_tdata[SLOW_BIT] !== want.slow_period)
          report_mismatch($sformatf("result %0d slow_period %b, want %b", results_seen,
                                    m_axis_tdata[SLOW_BIT], want.slow_period));
      end
    end
    // long hold-off on request, else random stall bursts
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(1, 11) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned phase_limit[NUM_PHASES];
    int unsigned acted;
    sls_item_t   it;
    logic        ant_level;
    int unsigned r;

    phase_limit = '{60, 1023, 1, 0, 3, 2};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    ant_level     = 1'b0;
    fault_limit   = LIMIT_RESET;
    leds          = '0;
    restart_sequence();

    // Lamp test from reset, a few run ticks with enable changes, then sleep and wake
    add_row(OP_TICK,   0, 0, 0, 0, 2'd0,     0, 1, 5'b00000);
    add_row(OP_SET_EN, 0, 0, 0, 0, 2'd3,     0, 1, 5'b00000);
    add_row(OP_TICK,   1, 1, 1, 1, 2'd3,     1, 1, 5'b00000);
    add_row(OP_TICK,   0, 1, 0, 1, 2'd1,     0, 0, '0);
    add_row(OP_TICK,   1, 0, 1, 0, 2'd2,     1, 0, '0);
    add_row(OP_TICK,   0, 0, 1, 1, 2'd0,     0, 0, '0);
    add_row(OP_TICK,   1, 1, 0, 0, 2'd3,     1, 1, 5'b10000);
    add_row(OP_TICK,   0, 0, 0, 0, 2'd0,     0, 1, 5'b11000);
    add_row(OP_TICK,   1, 1, 1, 1, 2'd3,     1, 1, 5'b11010);
    add_row(OP_TICK,   0, 0, 0, 0, 2'd0,     0, 1, 5'b11110);
    add_row(OP_TICK,   1, 1, 1, 1, 2'd3,     1, 1, 5'b00000);
    add_row(OP_TICK,   0, 1, 0, 1, 2'd1,     1, 0, '0);
    add_row(OP_TICK,   1, 0, 1, 0, 2'd2,     0, 0, '0);
    add_row(OP_TICK,   0, 0, 0, 1, 2'd0,     1, 0, '0);
    add_row(OP_TICK,   1, 1, 1, 0, 2'd1,     0, 0, '0);
    add_row(OP_TICK,   0, 0, 0, 0, 2'd0,     0, 1, 5'b00001);
    add_row(OP_TICK,   1, 1, 1, 1, 2'd0,     0, 1, 5'b11111);
    add_row(OP_SET_EN, 0, 0, 0, 0, SEL_SAT,  0, 0, '0);
    add_row(OP_TICK,   0, 1, 0, 1, 2'd0,     0, 0, '0);
    add_row(OP_SET_EN, 1, 1, 1, 1, SEL_CELL, 0, 0, '0);
    add_row(OP_TICK,   1, 1, 1, 1, 2'd3,     1, 0, '0);
    add_row(OP_SLEEP,  1, 1, 1, 1, 2'd3,     1, 1, 5'b00000);
    add_row(OP_TICK,   1, 1, 1, 1, 2'd0,     1, 1, 5'b00000);
    add_row(OP_SET_EN, 0, 0, 0, 0, SEL_BUS,  1, 1, 5'b00000);
    add_row(OP_WAKE,   0, 0, 0, 0, 2'd0,     0, 1, 5'b00000);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_limit_reg();

    foreach (stim_rows[i])
      send_event(stim_rows[i].item, stim_rows[i].has_fixed, stim_rows[i].fixed);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        // new limit while idle, upper data bits are don't-care
        wait_drained();
        apb_write({REG_FAULT_LIMIT, 2'b00},
                  ($urandom() << LIMIT_W) | phase_limit[p]);
        check_limit_reg();
        if (p == 4) begin
          // address of a register that does not exist: no effect
          apb_write(3'd4, $urandom());
          check_limit_reg();
        end
      end
      idle_en = (p != 3) && (p != NUM_PHASES - 1);
      if (p == 1) hold_req = LONG_HOLD;

      acted = 0;
      while (acted < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (sleeping)
          it.operation = (r < 30) ? OP_WAKE : (r < 80) ? OP_TICK :
                         (r < 95) ? OP_SET_EN : OP_SLEEP;
        else
          it.operation = (r < 82) ? OP_TICK : (r < 93) ? OP_SET_EN :
                         (r < 97) ? OP_SLEEP : OP_WAKE;
        // antenna short comes in streaks
        if ($urandom_range(0, 9) == 0) ant_level = ~ant_level;
        it.antenna_short  = ant_level;
        it.bus_busy       = ($urandom_range(0, 3) != 0);
        it.cell_connected = ($urandom_range(0, 3) != 0);
        it.position_fixed = ($urandom_range(0, 4) != 0);
        it.led_select     = 2'($urandom_range(0, 3));
        it.enable_value   = ($urandom_range(0, 2) != 0);
        if (!((it.operation == OP_TICK && sleeping) ||
              (it.operation == OP_SET_EN && it.led_select > SEL_SAT)))
          acted++;
        send_event(it, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Sent %0d items, checked %0d results over %0d fault limit settings,",
             items_sent, results_seen, NUM_PHASES);
    $display("covering the lamp test, run ticks, antenna faults, enables, sleep and wake.");
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
